FILE: hw/rtl/mros_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mros_pkg
// shared types and constants of the mean reversion order signal block
// ----------------------------------------------------------------------------
package mros_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_THRESHOLD = 1'b0,
    CFG_LOT_SIZE        = 1'b1
  } cfg_idx_e;

  localparam logic [CFG_DATA_W-1:0] ENTRY_THRESHOLD_RST = 16'd3;
  localparam logic [CFG_DATA_W-1:0] LOT_SIZE_RST        = 16'd10;

  // order side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // position held by the strategy
  typedef enum logic [1:0] {
    POS_FLAT  = 2'd0,
    POS_LONG  = 2'd1,
    POS_SHORT = 2'd2
  } pos_e;

  // market tick
  typedef struct packed {
    logic [31:0] bid_price;
    logic [31:0] ask_price;
    logic [63:0] tick_time;
  } mros_in_t;

  // market order
  typedef struct packed {
    logic        order_side;
    logic [15:0] order_qty;
    logic [63:0] order_time;
  } mros_out_t;

  // price against rolling mean comparisons for one tick
  typedef struct packed {
    logic full;        // window holds a full set of mids
    logic buy_open;    // ask below mean minus threshold
    logic sell_open;   // bid above mean plus threshold
    logic sell_close;  // bid at or above mean
    logic buy_close;   // ask at or below mean
  } mros_flags_t;

endpackage

FILE: hw/rtl/mros_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mros_window
// circular window of mid prices with running sum and full flag
// ----------------------------------------------------------------------------
module mros_window #(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic [31:0]                          mid_i,
  output logic [32+$clog2(WINDOW_LEN)-1:0]     sum_o,
  output logic                                 full_o
);

  localparam int unsigned SUM_W  = 32 + $clog2(WINDOW_LEN);
  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  logic [31:0]       mid_mem [WINDOW_LEN];
  logic [31:0]       old_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              full_q, full_d;
  logic [SUM_W-1:0]  drop;

  always_comb begin
    slot_d = slot_q;
    if (push_i) begin
      slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  // entry at slot_q is the oldest mid once the window is full
  assign drop   = full_q ? SUM_W'(old_q) : '0;
  assign sum_d  = push_i ? (sum_q - drop + SUM_W'(mid_i)) : sum_q;
  assign full_d = full_q | (push_i & (slot_q == LAST_SLOT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      sum_q  <= '0;
      full_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      sum_q  <= sum_d;
      full_q <= full_d;
    end
  end

  // read ahead at the next slot, never the one written this cycle
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mid_mem[slot_q] <= mid_i;
    end
    old_q <= mid_mem[slot_d];
  end

  assign sum_o  = sum_d;
  assign full_o = full_d;

endmodule

FILE: hw/rtl/mros_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mros_position
// position state machine choosing the order for one tick
// ----------------------------------------------------------------------------
module mros_position (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  mros_pkg::mros_flags_t flags_i,
  output logic                 emit_o,
  output logic                 side_o
);

  import mros_pkg::*;

  pos_e pos_q, pos_d;

  // order decision
  always_comb begin
    emit_o = 1'b0;
    side_o = SIDE_BUY;
    unique case (pos_q)
      POS_LONG: begin
        emit_o = flags_i.full & flags_i.sell_close;
        side_o = SIDE_SELL;
      end
      POS_SHORT: begin
        emit_o = flags_i.full & flags_i.buy_close;
        side_o = SIDE_BUY;
      end
      default: begin
        if (flags_i.buy_open) begin
          emit_o = flags_i.full;
          side_o = SIDE_BUY;
        end else if (flags_i.sell_open) begin
          emit_o = flags_i.full;
          side_o = SIDE_SELL;
        end
      end
    endcase
  end

  // next position
  always_comb begin
    pos_d = pos_q;
    if (advance_i && emit_o) begin
      unique case (pos_q)
        POS_LONG:  pos_d = POS_FLAT;
        POS_SHORT: pos_d = POS_FLAT;
        default:   pos_d = (side_o == SIDE_BUY) ? POS_LONG : POS_SHORT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_FLAT;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: hw/rtl/mean_reversion_order_signal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_reversion_order_signal_top
// rolling mean reversion strategy turning market ticks into market orders
// ----------------------------------------------------------------------------
// One tick is taken per clock cycle at full rate unless stalled; ticks move
// through the pipeline stages and an order (if any) is registered for output.
// The rate is set by the running-sum update of the mid-price window and by
// the position register, each closing a feedback loop. Ticks produce no order
// until the window holds WINDOW_LEN mids; the filling tick is already evaluated.
// The rolling mean is never divided out: each comparison against
// floor(sum / WINDOW_LEN) is rewritten as an exact compare of the sum against
// a price times the constant WINDOW_LEN. The input side keeps taking ticks
// while an order waits on a stalled output as long as the pipeline has room.
// Configuration must be written only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module mean_reversion_order_signal_top #(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mros_pkg::mros_in_t                   in_data_i,
  // order channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mros_pkg::mros_out_t                  out_data_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [mros_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mros_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  import mros_pkg::*;

  localparam int unsigned SUM_W  = 32 + $clog2(WINDOW_LEN);
  localparam int unsigned PROD_W = 33 + $clog2(WINDOW_LEN + 1);
  localparam logic [PROD_W-1:0] WIN_K = PROD_W'(WINDOW_LEN);

  // configuration registers
  logic [15:0] thr_q, lot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ENTRY_THRESHOLD_RST;
      lot_q <= LOT_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENTRY_THRESHOLD: thr_q <= cfg_wdata_i;
        CFG_LOT_SIZE:        lot_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control: each stage moves when the next one has room
  logic s1_v_q, s2_v_q, s3_v_q, out_valid_q;
  logic out_ready, ready1, ready2, ready3;
  logic load1, move12, move23, fire3;
  logic dec_emit, dec_side;

  assign out_ready = !out_valid_q || !out_stall_i;
  // a tick that gives no order never waits on the output register
  assign ready3    = !s3_v_q || !dec_emit || out_ready;
  assign ready2    = !s2_v_q || ready3;
  assign ready1    = !s1_v_q || ready2;

  assign in_stall_o = !ready1;
  assign load1      = in_valid_i && ready1;
  assign move12     = s1_v_q && ready2;
  assign move23     = s2_v_q && ready3;
  assign fire3      = s3_v_q && ready3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load1)       s1_v_q <= 1'b1;
      else if (move12) s1_v_q <= 1'b0;
      if (move12)      s2_v_q <= 1'b1;
      else if (move23) s2_v_q <= 1'b0;
      if (move23)      s3_v_q <= 1'b1;
      else if (fire3)  s3_v_q <= 1'b0;
      if (fire3 && dec_emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // stage 1: registered tick with its mid price
  logic [31:0] s1_bid_q, s1_ask_q, s1_mid_q;
  logic [63:0] s1_time_q;
  logic [32:0] mid_sum;

  assign mid_sum = 33'(in_data_i.bid_price) + 33'(in_data_i.ask_price);

  always_ff @(posedge clk_i) begin
    if (load1) begin
      s1_bid_q  <= in_data_i.bid_price;
      s1_ask_q  <= in_data_i.ask_price;
      s1_time_q <= in_data_i.tick_time;
      s1_mid_q  <= mid_sum[32:1];
    end
  end

  // window update happens as the tick leaves stage 1
  logic [SUM_W-1:0] win_sum;
  logic             win_full;

  mros_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (move12),
    .mid_i  (s1_mid_q),
    .sum_o  (win_sum),
    .full_o (win_full)
  );

  // stage 2: tick with the window sum that includes it
  logic [31:0]      s2_bid_q, s2_ask_q;
  logic [63:0]      s2_time_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic             s2_full_q;

  always_ff @(posedge clk_i) begin
    if (move12) begin
      s2_bid_q  <= s1_bid_q;
      s2_ask_q  <= s1_ask_q;
      s2_time_q <= s1_time_q;
      s2_sum_q  <= win_sum;
      s2_full_q <= win_full;
    end
  end

  // limits scaled by the window length, mean = floor(sum / WINDOW_LEN):
  //   ask < mean - thr  <=>  (ask + thr + 1) * len <= sum
  //   bid > mean + thr  <=>  bid > thr and sum < (bid - thr) * len
  //   bid >= mean       <=>  sum < (bid + 1) * len
  //   ask <= mean       <=>  ask * len <= sum
  logic [32:0]       ask_thr1, bid_inc;
  logic [31:0]       bid_less_thr;
  logic              bid_gt_thr;
  logic [PROD_W-1:0] lim_bo, lim_so, lim_sc, lim_bc;

  assign ask_thr1     = 33'(s2_ask_q) + 33'(thr_q) + 33'd1;
  assign bid_inc      = 33'(s2_bid_q) + 33'd1;
  assign bid_gt_thr   = s2_bid_q > 32'(thr_q);
  assign bid_less_thr = s2_bid_q - 32'(thr_q);
  assign lim_bo       = PROD_W'(ask_thr1) * WIN_K;
  assign lim_so       = PROD_W'(bid_less_thr) * WIN_K;
  assign lim_sc       = PROD_W'(bid_inc) * WIN_K;
  assign lim_bc       = PROD_W'(s2_ask_q) * WIN_K;

  // stage 3: scaled limits
  logic [PROD_W-1:0] s3_bo_q, s3_so_q, s3_sc_q, s3_bc_q;
  logic [SUM_W-1:0]  s3_sum_q;
  logic [63:0]       s3_time_q;
  logic              s3_full_q, s3_gt_q;

  always_ff @(posedge clk_i) begin
    if (move23) begin
      s3_bo_q   <= lim_bo;
      s3_so_q   <= lim_so;
      s3_sc_q   <= lim_sc;
      s3_bc_q   <= lim_bc;
      s3_sum_q  <= s2_sum_q;
      s3_time_q <= s2_time_q;
      s3_full_q <= s2_full_q;
      s3_gt_q   <= bid_gt_thr;
    end
  end

  mros_flags_t       s3_flags;
  logic [PROD_W-1:0] s3_sum_ext;

  assign s3_sum_ext          = PROD_W'(s3_sum_q);
  assign s3_flags.full       = s3_full_q;
  assign s3_flags.buy_open   = s3_bo_q <= s3_sum_ext;
  assign s3_flags.sell_open  = s3_gt_q && (s3_sum_ext < s3_so_q);
  assign s3_flags.sell_close = s3_sum_ext < s3_sc_q;
  assign s3_flags.buy_close  = s3_bc_q <= s3_sum_ext;

  mros_position u_position (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (fire3),
    .flags_i   (s3_flags),
    .emit_o    (dec_emit),
    .side_o    (dec_side)
  );

  // order register
  mros_out_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (fire3 && dec_emit) begin
      out_data_q.order_side <= dec_side;
      out_data_q.order_qty  <= lot_q;
      out_data_q.order_time <= s3_time_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an empty input stage always takes a tick
  a_empty_takes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // a decision stage blocked by the output keeps its tick
  a_stage3_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !ready3) |=> (s3_v_q && $stable(s3_time_q)))
    else $error("blocked tick lost from decision stage");

  // orders only come from a full window
  a_order_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire3 && dec_emit) |-> s3_flags.full)
    else $error("order issued before window filled");

endmodule
